FILE: src/sgs_pkg.sv
`default_nettype none
package sgs_pkg;

	localparam int ADDR_BITS_DEF = 48;

	localparam int SRC_ADDR_W = 48;
	localparam int BSIZE_W    = 32;
	localparam int STRIDE_W   = 40;
	localparam int COUNT_W    = 32;
	localparam int LEN_W      = 32;
	localparam int BYTES_W    = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;
	localparam int KIND_W     = 2;
	localparam int SLOT_W     = 2;
	localparam int NUM_SLOTS  = 3;
	localparam int DIV_CNT_W  = 5;

	localparam logic [KIND_W-1:0] KIND_COPY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RUN  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PTR  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_TOTAL = 2'd3;

	typedef struct packed {
		logic              load_in;
		logic              load_total;
		logic              put_fin;
		logic              do_nb;
		logic              load_rem;
		logic              start;
		logic              do_tail;
		logic              div_start;
		logic              div_step;
		logic              do_run;
		logic              do_head;
		logic              set_done;
		logic              load_out;
		logic [SLOT_W-1:0] ei;
	} sgs_cmd_t;

	typedef struct packed {
		logic fin;
		logic nobuf;
		logic rem_zero;
		logic tail_ok;
		logic bl_zero;
		logic run_ok;
		logic div_last;
		logic emit_last;
	} sgs_status_t;

endpackage
`default_nettype wire

FILE: src/strided_gather_segmenter_core.sv
// Channel   Handshake             Payload
// cfg       cfg_write             cfg_index, cfg_data
// in        in_valid / in_ready   seg_len, no_buffer
// out       out_valid / out_ready kind, src_addr, dst_offset, piece_len, repeat_res,
//                                 done_res, last
//
// One segment at a time. A segment transfer is followed by the total load and the check;
// a finished transfer then loads its first result, pointer mode passes the done state
// first, and a copy segment goes through the remainder, tail, run, head and done states,
// a strided run dividing by block size one quotient bit per cycle. Results leave one per
// cycle while out_ready is high; a stalled output holds its register, and the next
// segment is taken while the last result waits. arst_n loads the register defaults.
`default_nettype none
module strided_gather_segmenter_core import sgs_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [LEN_W-1:0]      seg_len,
	input  wire logic                  no_buffer,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [KIND_W-1:0]          kind,
	output logic [SRC_ADDR_W-1:0]      src_addr,
	output logic [LEN_W-1:0]           dst_offset,
	output logic [LEN_W-1:0]           piece_len,
	output logic [COUNT_W-1:0]         repeat_res,
	output logic                       done_res,
	output logic                       last
);

	sgs_cmd_t    cmd;
	sgs_status_t status;

	sgs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	sgs_datapath #(
		.ADDR_BITS (ADDR_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.seg_len    (seg_len),
		.no_buffer  (no_buffer),
		.cmd        (cmd),
		.status     (status),
		.kind       (kind),
		.src_addr   (src_addr),
		.dst_offset (dst_offset),
		.piece_len  (piece_len),
		.repeat_res (repeat_res),
		.done_res   (done_res),
		.last       (last)
	);

`ifndef SYNTH
	a_no_load_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !cmd.load_out)
		else $error("output loaded right after a segment transfer");

	a_none_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_NONE) |-> (done_res && last))
		else $error("finished-transfer result without done and last");

	a_run_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_RUN) |-> (repeat_res != '0))
		else $error("strided run with zero blocks");

	a_run_after_divide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_run |-> $past(cmd.div_step))
		else $error("run committed without a finished divide");
`endif

endmodule
`default_nettype wire

FILE: src/sgs_datapath.sv
`default_nettype none
module sgs_datapath import sgs_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [LEN_W-1:0]      seg_len,
	input  wire logic                  no_buffer,
	input  wire sgs_cmd_t              cmd,
	output sgs_status_t                status,
	output logic [KIND_W-1:0]          kind,
	output logic [SRC_ADDR_W-1:0]      src_addr,
	output logic [LEN_W-1:0]           dst_offset,
	output logic [LEN_W-1:0]           piece_len,
	output logic [COUNT_W-1:0]         repeat_res,
	output logic                       done_res,
	output logic                       last
);

	localparam int AXW = (ADDR_BITS > SRC_ADDR_W) ? ADDR_BITS : SRC_ADDR_W;
	localparam int SXW = (ADDR_BITS > STRIDE_W) ? ADDR_BITS : STRIDE_W;

	// configuration
	logic [SRC_ADDR_W-1:0] base_q;
	logic [BSIZE_W-1:0]    bsize_q;
	logic [STRIDE_W-1:0]   stride_q;
	logic [COUNT_W-1:0]    btotal_q;

	// transfer position
	logic [COUNT_W-1:0]   bl_q;
	logic [ADDR_BITS-1:0] boff_q;
	logic [LEN_W-1:0]     inside_q;
	logic [BYTES_W-1:0]   bdone_q;

	// per-segment work
	logic [LEN_W-1:0]     seg_q;
	logic                 nobuf_q;
	logic [BYTES_W-1:0]   total_q;
	logic [LEN_W-1:0]     rem_q;
	logic [LEN_W-1:0]     dst_q;
	logic                 done_q;
	logic [SLOT_W-1:0]    nres_q;

	// serial divider with shift-add product of quotient and stride
	logic [BSIZE_W-1:0]   pr_q;
	logic [LEN_W-1:0]     dvd_q;
	logic [COUNT_W-1:0]   quot_q;
	logic [ADDR_BITS-1:0] prod_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	// result slots
	logic [KIND_W-1:0]     slot_kind_q [NUM_SLOTS];
	logic [SRC_ADDR_W-1:0] slot_addr_q [NUM_SLOTS];
	logic [LEN_W-1:0]      slot_dst_q  [NUM_SLOTS];
	logic [LEN_W-1:0]      slot_len_q  [NUM_SLOTS];
	logic [COUNT_W-1:0]    slot_rep_q  [NUM_SLOTS];

	logic [BSIZE_W-1:0]    bs;
	logic [BYTES_W-1:0]    total_d;
	logic [BYTES_W-1:0]    left_bytes;
	logic [LEN_W-1:0]      rem_d;
	logic [LEN_W-1:0]      len_tail;
	logic [AXW-1:0]        base_x;
	logic [SXW-1:0]        stride_x;
	logic [ADDR_BITS-1:0]  base_a;
	logic [ADDR_BITS-1:0]  stride_a;
	logic [ADDR_BITS-1:0]  sum_a;
	logic [AXW-1:0]        sum_x;
	logic [SRC_ADDR_W-1:0] cur_addr;
	logic [BSIZE_W:0]      trial;
	logic                  qbit;
	logic [BSIZE_W:0]      trial_sub;
	logic                  fin;

	logic                  wr_en;
	logic [KIND_W-1:0]     wr_kind;
	logic [SRC_ADDR_W-1:0] wr_addr;
	logic [LEN_W-1:0]      wr_dst;
	logic [LEN_W-1:0]      wr_len;
	logic [COUNT_W-1:0]    wr_rep;

	assign bs         = (bsize_q == '0) ? BSIZE_W'(1) : bsize_q;
	assign total_d    = BYTES_W'(btotal_q) * BYTES_W'(bs);
	assign left_bytes = total_q - bdone_q;
	assign rem_d      = (left_bytes > BYTES_W'(seg_q)) ? seg_q : left_bytes[LEN_W-1:0];
	assign len_tail   = (inside_q < bs) ? (bs - inside_q) : '0;

	assign base_x   = AXW'(base_q);
	assign base_a   = base_x[ADDR_BITS-1:0];
	assign stride_x = SXW'(stride_q);
	assign stride_a = stride_x[ADDR_BITS-1:0];
	assign sum_a    = base_a + boff_q + ADDR_BITS'(inside_q);
	assign sum_x    = AXW'(sum_a);
	assign cur_addr = sum_x[SRC_ADDR_W-1:0];

	assign trial     = {pr_q, dvd_q[LEN_W-1]};
	assign qbit      = (trial >= {1'b0, bs});
	assign trial_sub = trial - {1'b0, bs};

	assign fin = (bl_q == '0) || (bdone_q >= total_q);

	assign status.fin       = fin;
	assign status.nobuf     = nobuf_q;
	assign status.rem_zero  = (rem_q == '0);
	assign status.tail_ok   = (inside_q != '0) && (len_tail <= rem_q);
	assign status.bl_zero   = (bl_q == '0);
	assign status.run_ok    = (bs <= rem_q);
	assign status.div_last  = (cnt_q == '0);
	assign status.emit_last = (cmd.ei == nres_q - SLOT_W'(1));

	always_comb begin
		wr_en   = cmd.put_fin | cmd.do_nb | cmd.do_tail | cmd.do_run | cmd.do_head;
		wr_kind = KIND_NONE;
		wr_addr = '0;
		wr_dst  = '0;
		wr_len  = '0;
		wr_rep  = '0;
		if (cmd.do_nb) begin
			wr_kind = KIND_PTR;
			wr_addr = cur_addr;
			wr_len  = len_tail;
			wr_rep  = COUNT_W'(1);
		end else if (cmd.do_tail) begin
			wr_kind = KIND_COPY;
			wr_addr = cur_addr;
			wr_dst  = dst_q;
			wr_len  = len_tail;
			wr_rep  = COUNT_W'(1);
		end else if (cmd.do_run) begin
			wr_kind = KIND_RUN;
			wr_addr = cur_addr;
			wr_dst  = dst_q;
			wr_len  = bs;
			wr_rep  = quot_q;
		end else if (cmd.do_head) begin
			wr_kind = KIND_COPY;
			wr_addr = cur_addr;
			wr_dst  = dst_q;
			wr_len  = rem_q;
			wr_rep  = COUNT_W'(1);
		end
	end

	// configuration and transfer position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			bsize_q  <= BSIZE_W'(1);
			stride_q <= STRIDE_W'(1);
			btotal_q <= COUNT_W'(1);
			bl_q     <= COUNT_W'(1);
			boff_q   <= '0;
			inside_q <= '0;
			bdone_q  <= '0;
			nres_q   <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_SOURCE_BASE: base_q <= cfg_data[SRC_ADDR_W-1:0];
					REG_BLOCK_SIZE:  bsize_q <= cfg_data[BSIZE_W-1:0];
					REG_STRIDE:      stride_q <= cfg_data[STRIDE_W-1:0];
					REG_BLOCK_TOTAL: begin
						// new transfer
						btotal_q <= cfg_data[COUNT_W-1:0];
						bl_q     <= cfg_data[COUNT_W-1:0];
						boff_q   <= '0;
						inside_q <= '0;
						bdone_q  <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.load_in) begin
				nres_q <= '0;
			end
			if (wr_en) begin
				nres_q <= nres_q + SLOT_W'(1);
			end
			if (cmd.do_nb) begin
				bdone_q  <= bdone_q + BYTES_W'(len_tail);
				boff_q   <= boff_q + stride_a;
				bl_q     <= (bl_q == '0) ? '0 : bl_q - COUNT_W'(1);
				inside_q <= '0;
			end
			if (cmd.start) begin
				bdone_q <= bdone_q + BYTES_W'(rem_q);
			end
			if (cmd.do_tail) begin
				boff_q   <= boff_q + stride_a;
				bl_q     <= (bl_q == '0) ? '0 : bl_q - COUNT_W'(1);
				inside_q <= '0;
			end
			if (cmd.do_run) begin
				boff_q <= boff_q + prod_q;
				bl_q   <= (quot_q >= bl_q) ? '0 : bl_q - quot_q;
			end
			if (cmd.do_head) begin
				inside_q <= inside_q + rem_q;
			end
		end
	end

	// segment work registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			seg_q   <= seg_len;
			nobuf_q <= no_buffer;
		end
		if (cmd.load_total) begin
			total_q <= total_d;
		end
		if (cmd.load_rem) begin
			rem_q <= rem_d;
		end
		if (cmd.start) begin
			dst_q <= '0;
		end
		if (cmd.do_tail) begin
			dst_q <= dst_q + len_tail;
			rem_q <= rem_q - len_tail;
		end
		if (cmd.div_start) begin
			pr_q   <= '0;
			dvd_q  <= rem_q;
			quot_q <= '0;
			prod_q <= '0;
			cnt_q  <= DIV_CNT_W'(LEN_W - 1);
		end
		if (cmd.div_step) begin
			pr_q   <= qbit ? trial_sub[BSIZE_W-1:0] : trial[BSIZE_W-1:0];
			dvd_q  <= {dvd_q[LEN_W-2:0], 1'b0};
			quot_q <= {quot_q[COUNT_W-2:0], qbit};
			prod_q <= {prod_q[ADDR_BITS-2:0], 1'b0} + (qbit ? stride_a : '0);
			cnt_q  <= cnt_q - DIV_CNT_W'(1);
		end
		if (cmd.do_run) begin
			// remainder of the division is what the head copy takes
			dst_q <= dst_q + (rem_q - pr_q);
			rem_q <= pr_q;
		end
		if (cmd.put_fin) begin
			done_q <= 1'b1;
		end
		if (cmd.set_done) begin
			done_q <= fin;
		end
		if (wr_en) begin
			slot_kind_q[nres_q] <= wr_kind;
			slot_addr_q[nres_q] <= wr_addr;
			slot_dst_q[nres_q]  <= wr_dst;
			slot_len_q[nres_q]  <= wr_len;
			slot_rep_q[nres_q]  <= wr_rep;
		end
		if (cmd.load_out) begin
			kind       <= slot_kind_q[cmd.ei];
			src_addr   <= slot_addr_q[cmd.ei];
			dst_offset <= slot_dst_q[cmd.ei];
			piece_len  <= slot_len_q[cmd.ei];
			repeat_res <= slot_rep_q[cmd.ei];
			done_res   <= done_q;
			last       <= status.emit_last;
		end
	end

endmodule
`default_nettype wire

FILE: src/sgs_ctrl.sv
`default_nettype none
module sgs_ctrl import sgs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire sgs_status_t status,
	output sgs_cmd_t         cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TOT,
		ST_CHK,
		ST_REM,
		ST_TAIL,
		ST_TCHK,
		ST_RUN,
		ST_DIV,
		ST_RUNW,
		ST_HEAD,
		ST_DONE,
		ST_EMIT
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic              out_valid_q;
	logic [SLOT_W-1:0] ei_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		cmd.ei  = ei_q;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_TOT;
				end
			end
			ST_TOT: begin
				cmd.load_total = 1'b1;
				state_d        = ST_CHK;
			end
			ST_CHK: begin
				if (status.fin) begin
					cmd.put_fin = 1'b1;
					state_d     = ST_EMIT;
				end else if (status.nobuf) begin
					cmd.do_nb = 1'b1;
					state_d   = ST_DONE;
				end else begin
					cmd.load_rem = 1'b1;
					state_d      = ST_REM;
				end
			end
			ST_REM: begin
				// empty segment: drop it without a result
				if (status.rem_zero) begin
					state_d = ST_IDLE;
				end else begin
					cmd.start = 1'b1;
					state_d   = ST_TAIL;
				end
			end
			ST_TAIL: begin
				if (status.tail_ok) begin
					cmd.do_tail = 1'b1;
					state_d     = ST_TCHK;
				end else begin
					state_d = ST_RUN;
				end
			end
			ST_TCHK: begin
				state_d = status.bl_zero ? ST_DONE : ST_RUN;
			end
			ST_RUN: begin
				if (status.run_ok) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_HEAD;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_RUNW;
				end
			end
			ST_RUNW: begin
				cmd.do_run = 1'b1;
				state_d    = ST_HEAD;
			end
			ST_HEAD: begin
				cmd.do_head = !status.rem_zero;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				cmd.set_done = 1'b1;
				state_d      = ST_EMIT;
			end
			ST_EMIT: begin
				// advance one slot per free output register
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					if (status.emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			ei_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q != ST_EMIT) begin
				ei_q <= '0;
			end else if (cmd.load_out) begin
				ei_q <= ei_q + SLOT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: tb/strided_gather_segmenter_core_tb.sv
`timescale 1ns / 100ps
module strided_gather_segmenter_core_tb;
	import sgs_pkg::*;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [SRC_ADDR_W-1:0] src;
		logic [LEN_W-1:0]      dst;
		logic [LEN_W-1:0]      len;
		logic [COUNT_W-1:0]    rep;
		logic                  done;
		logic                  last;
	} copy_cmd_t;

	typedef struct {
		bit             is_cfg;
		logic [1:0]     idx;
		logic [63:0]    val;
		logic [31:0]    seg;
		logic           nb;
		bit             typed;
		copy_cmd_t      want;
	} plan_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [LEN_W-1:0] seg_len = '0;
	logic no_buffer = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [KIND_W-1:0] kind;
	logic [SRC_ADDR_W-1:0] src_addr;
	logic [LEN_W-1:0] dst_offset;
	logic [LEN_W-1:0] piece_len;
	logic [COUNT_W-1:0] repeat_res;
	logic done_res;
	logic last;

	strided_gather_segmenter_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .seg_len(seg_len), .no_buffer(no_buffer),
		.out_valid(out_valid), .out_ready(out_ready), .kind(kind), .src_addr(src_addr),
		.dst_offset(dst_offset), .piece_len(piece_len), .repeat_res(repeat_res),
		.done_res(done_res), .last(last)
	);

	// shadow registers and transfer position
	logic [47:0] base_r;
	logic [31:0] bsize_r;
	logic [39:0] stride_r;
	logic [31:0] total_r;
	logic [31:0] blocks_left;
	logic [47:0] block_off;
	logic [31:0] in_off;
	logic [63:0] bytes_packed;

	copy_cmd_t seg_cmds[3];
	copy_cmd_t pending_cmds[$];
	copy_cmd_t seen, want_cmd;

	int errors = 0;
	int segs_sent = 0;
	int ptr_segs = 0;
	int cmds_checked = 0;
	int reg_writes = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_cnt = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL strided_gather_segmenter_core");
		$finish;
	end

	function automatic copy_cmd_t mk_cmd(logic [KIND_W-1:0] k, logic [47:0] src,
		logic [31:0] dst, logic [31:0] len, logic [31:0] rep, logic d, logic l);
		copy_cmd_t c;
		c.kind = k;
		c.src = src;
		c.dst = dst;
		c.len = len;
		c.rep = rep;
		c.done = d;
		c.last = l;
		return c;
	endfunction

	function automatic logic [63:0] eff_bsize();
		return (bsize_r == 0) ? 64'd1 : {32'd0, bsize_r};
	endfunction

	function automatic bit xfer_finished();
		return blocks_left == 0 || bytes_packed >= {32'd0, total_r} * eff_bsize();
	endfunction

	function automatic logic [47:0] cur_src();
		return base_r + block_off + {16'd0, in_off};
	endfunction

	function automatic void skip_blocks(logic [63:0] cnt);
		blocks_left = (cnt >= {32'd0, blocks_left}) ? 32'd0 : blocks_left - cnt[31:0];
	endfunction

	function automatic void restart_xfer();
		blocks_left = total_r;
		block_off = '0;
		in_off = '0;
		bytes_packed = '0;
	endfunction

	// Advance the position by one segment and leave its commands in seg_cmds.
	function automatic int pack_segment(logic [31:0] seg, logic nb);
		logic [63:0] bs, total, rem, dst, len, full, prod;
		bit stop;
		bit fin;
		int n;
		bs = eff_bsize();
		total = {32'd0, total_r} * bs;
		n = 0;
		stop = 0;
		dst = '0;
		if (xfer_finished()) begin
			seg_cmds[0] = mk_cmd(KIND_NONE, '0, '0, '0, '0, 1'b1, 1'b1);
			return 1;
		end
		len = ({32'd0, in_off} < bs) ? bs - {32'd0, in_off} : 64'd0;
		if (nb) begin
			seg_cmds[n] = mk_cmd(KIND_PTR, cur_src(), '0, len[31:0], 32'd1, 1'b0, 1'b0);
			n = n + 1;
			bytes_packed = bytes_packed + len;
			block_off = block_off + {8'd0, stride_r};
			skip_blocks(64'd1);
			in_off = '0;
		end else begin
			rem = total - bytes_packed;
			if (rem > {32'd0, seg})
				rem = {32'd0, seg};
			if (rem == 0)
				return 0;
			bytes_packed = bytes_packed + rem;
			// finish the partly packed block first
			if (in_off != 0 && len <= rem) begin
				seg_cmds[n] = mk_cmd(KIND_COPY, cur_src(), dst[31:0], len[31:0], 32'd1,
					1'b0, 1'b0);
				n = n + 1;
				dst = dst + len;
				rem = rem - len;
				skip_blocks(64'd1);
				block_off = block_off + {8'd0, stride_r};
				in_off = '0;
				if (blocks_left == 0)
					stop = 1;
			end
			if (!stop && bs <= rem) begin
				full = rem / bs;
				seg_cmds[n] = mk_cmd(KIND_RUN, cur_src(), dst[31:0], bs[31:0], full[31:0],
					1'b0, 1'b0);
				n = n + 1;
				dst = dst + full * bs;
				rem = rem - full * bs;
				skip_blocks(full);
				prod = full * {24'd0, stride_r};
				block_off = block_off + prod[47:0];
			end
			if (!stop && rem != 0) begin
				seg_cmds[n] = mk_cmd(KIND_COPY, cur_src(), dst[31:0], rem[31:0], 32'd1,
					1'b0, 1'b0);
				n = n + 1;
				in_off = in_off + rem[31:0];
			end
		end
		fin = xfer_finished();
		for (int i = 0; i < n; i++)
			seg_cmds[i].done = fin;
		if (n > 0)
			seg_cmds[n - 1].last = 1'b1;
		return n;
	endfunction

	task automatic report_error(string msg);
		if (errors < 40)
			$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_error($sformatf("command %0d %s got 0x%0h want 0x%0h",
				cmds_checked, name, got, want));
	endtask

	task automatic set_idle(int mode);
		case (mode)
		0: begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
		1: begin
			send_idle_pct = 68;
			recv_stall_pct = 0;
		end
		2: begin
			send_idle_pct = 0;
			recv_stall_pct = 68;
		end
		default: begin
			send_idle_pct = 25;
			recv_stall_pct = 25;
		end
		endcase
	endtask

	// Drop valid, drain every expected command, then let an empty segment finish.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[47:0];
		@(posedge clk);
		cfg_write <= 1'b0;
		reg_writes++;
		case (idx)
		REG_SOURCE_BASE: base_r = val[47:0];
		REG_BLOCK_SIZE:  bsize_r = val[31:0];
		REG_STRIDE:      stride_r = val[39:0];
		REG_BLOCK_TOTAL: begin
			total_r = val[31:0];
			restart_xfer();
		end
		endcase
	endtask

	task automatic offer(logic [31:0] seg, logic nb, bit typed, copy_cmd_t want,
		output int produced);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		seg_len <= seg;
		no_buffer <= nb;
		do
			@(posedge clk);
		while (!in_ready);
		produced = pack_segment(seg, nb);
		if (typed)
			pending_cmds.push_back(want);
		else
			for (int i = 0; i < produced; i++)
				pending_cmds.push_back(seg_cmds[i]);
		segs_sent++;
		if (nb)
			ptr_segs++;
	endtask

	// output side: check each transfer, then pick the next ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_cmds.size() == 0) begin
				report_error("command arrived with none expected");
			end else begin
				want_cmd = pending_cmds.pop_front();
				seen = mk_cmd(kind, src_addr, dst_offset, piece_len, repeat_res, done_res,
					last);
				compare_field("kind", seen.kind, want_cmd.kind);
				compare_field("src_addr", seen.src, want_cmd.src);
				compare_field("dst_offset", seen.dst, want_cmd.dst);
				compare_field("piece_len", seen.len, want_cmd.len);
				compare_field("repeat_res", seen.rep, want_cmd.rep);
				compare_field("done_res", seen.done, want_cmd.done);
				compare_field("last", seen.last, want_cmd.last);
			end
			cmds_checked++;
		end
		if (hold_cnt == 0 && hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt = hold_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		plan_row_t plan[$];
		plan_row_t row;
		logic [63:0] bs_pick, stride_pick;
		logic [31:0] seg_pick, span;
		logic nb_pick;
		int produced;
		int ph;
		int rand_segs;

		base_r = '0;
		bsize_r = 32'd1;
		stride_r = 40'd1;
		total_r = 32'd1;
		restart_xfer();
		ph = 0;
		rand_segs = 0;

		row = '{default: '0};
		// after reset: empty segment, one block run, then nothing left
		row.seg = 32'd0;                   plan.push_back(row);
		row.seg = 32'hFFFF_FFFF; row.typed = 1;
		row.want = mk_cmd(KIND_RUN, '0, '0, 32'd1, 32'd1, 1'b1, 1'b1);
		plan.push_back(row);
		row.seg = 32'd5; row.nb = 1;
		row.want = mk_cmd(KIND_NONE, '0, '0, '0, '0, 1'b1, 1'b1);
		plan.push_back(row);
		row = '{default: '0};
		// zero block size, wrapping addresses
		row.is_cfg = 1; row.idx = REG_SOURCE_BASE; row.val = 64'hFFFF_FFFF_FFF0;
		plan.push_back(row);
		row.idx = REG_BLOCK_SIZE;  row.val = 64'd0;              plan.push_back(row);
		row.idx = REG_STRIDE;      row.val = 64'hFF_FFFF_FFFF;   plan.push_back(row);
		row.idx = REG_BLOCK_TOTAL; row.val = 64'd4;              plan.push_back(row);
		row = '{default: '0};
		row.seg = 32'd2;                                         plan.push_back(row);
		row.seg = 32'hFFFF_FFFF; row.nb = 1;                     plan.push_back(row);
		row.seg = 32'd7; row.nb = 0;                             plan.push_back(row);
		// tail, run and head in one segment
		row = '{default: '0};
		row.is_cfg = 1; row.idx = REG_SOURCE_BASE; row.val = 64'h1000; plan.push_back(row);
		row.idx = REG_BLOCK_SIZE;  row.val = 64'd10;             plan.push_back(row);
		row.idx = REG_STRIDE;      row.val = 64'd16;             plan.push_back(row);
		row.idx = REG_BLOCK_TOTAL; row.val = 64'd3;              plan.push_back(row);
		row = '{default: '0};
		row.seg = 32'd4; row.typed = 1;
		row.want = mk_cmd(KIND_COPY, 48'h1000, '0, 32'd4, 32'd1, 1'b0, 1'b1);
		plan.push_back(row);
		row.typed = 0;
		row.seg = 32'd19;                                        plan.push_back(row);
		row.seg = 32'd3;                                         plan.push_back(row);
		row.seg = 32'd0; row.nb = 1;                             plan.push_back(row);
		row.seg = 32'd1; row.nb = 0; row.typed = 1;
		row.want = mk_cmd(KIND_NONE, '0, '0, '0, '0, 1'b1, 1'b1);
		plan.push_back(row);
		// tail copy that uses up the last block
		row = '{default: '0};
		row.is_cfg = 1; row.idx = REG_BLOCK_TOTAL; row.val = 64'd2; plan.push_back(row);
		row = '{default: '0};
		row.seg = 32'd15;                                        plan.push_back(row);
		row.seg = 32'hFFFF_FFFF;                                 plan.push_back(row);
		// shrink the block under a partial one: offset lands past its end
		row = '{default: '0};
		row.is_cfg = 1; row.idx = REG_BLOCK_TOTAL; row.val = 64'd5; plan.push_back(row);
		row = '{default: '0};
		row.seg = 32'd7;                                         plan.push_back(row);
		row = '{default: '0};
		row.is_cfg = 1; row.idx = REG_BLOCK_SIZE; row.val = 64'd4; plan.push_back(row);
		row = '{default: '0};
		row.seg = 32'd9;                                         plan.push_back(row);
		row.seg = 32'd5; row.nb = 1;                             plan.push_back(row);
		// grow the block mid-transfer: run outruns the block count
		row = '{default: '0};
		row.is_cfg = 1; row.idx = REG_BLOCK_TOTAL; row.val = 64'd4; plan.push_back(row);
		row = '{default: '0};
		row.seg = 32'd9;                                         plan.push_back(row);
		row = '{default: '0};
		row.is_cfg = 1; row.idx = REG_BLOCK_SIZE; row.val = 64'd10; plan.push_back(row);
		row = '{default: '0};
		row.seg = 32'd31;                                        plan.push_back(row);
		row.seg = 32'd3; row.typed = 1;
		row.want = mk_cmd(KIND_NONE, '0, '0, '0, '0, 1'b1, 1'b1);
		plan.push_back(row);
		// every register at its maximum
		row = '{default: '0};
		row.is_cfg = 1; row.idx = REG_SOURCE_BASE; row.val = 64'hFFFF_FFFF_FFFF;
		plan.push_back(row);
		row.idx = REG_BLOCK_SIZE;  row.val = 64'hFFFF_FFFF;      plan.push_back(row);
		row.idx = REG_STRIDE;      row.val = 64'hFF_FFFF_FFFF;   plan.push_back(row);
		row.idx = REG_BLOCK_TOTAL; row.val = 64'hFFFF_FFFF;      plan.push_back(row);
		row = '{default: '0};
		row.seg = 32'hFFFF_FFFF;                                 plan.push_back(row);
		row.seg = 32'd0; row.nb = 1;                             plan.push_back(row);
		row.seg = 32'd1; row.nb = 0;                             plan.push_back(row);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idle(3);
		foreach (plan[k]) begin
			if (plan[k].is_cfg) begin
				settle();
				write_reg(plan[k].idx, plan[k].val);
			end else begin
				offer(plan[k].seg, plan[k].nb, plan[k].typed, plan[k].want, produced);
			end
		end

		while (rand_segs < 70) begin
			set_idle(ph % 4);
			settle();
			if (!xfer_finished() && $urandom_range(0, 3) == 0) begin
				// change the block size without restarting the transfer
				write_reg(REG_BLOCK_SIZE, $urandom_range(1, 24));
			end else begin
				case ($urandom_range(0, 9))
				0: bs_pick = {32'd0, $urandom};
				1: bs_pick = 64'd0;
				default: bs_pick = $urandom_range(1, 24);
				endcase
				if ($urandom_range(0, 3) == 0)
					stride_pick = {$urandom, $urandom} & 64'hFF_FFFF_FFFF;
				else
					stride_pick = bs_pick + $urandom_range(1, 40);
				write_reg(REG_SOURCE_BASE, {$urandom, $urandom});
				write_reg(REG_BLOCK_SIZE, bs_pick);
				write_reg(REG_STRIDE, stride_pick);
				write_reg(REG_BLOCK_TOTAL, $urandom_range(1, 30));
			end
			for (int j = 0; j < 12 && rand_segs < 70; j++) begin
				span = (bsize_r == 0 || bsize_r > 64) ? 32'd64 : bsize_r;
				case ($urandom_range(0, 9))
				0: seg_pick = 32'd0;
				1: seg_pick = $urandom;
				2: seg_pick = $urandom_range(1, 3);
				default: seg_pick = $urandom_range(1, 3 * span + 4);
				endcase
				nb_pick = ($urandom_range(0, 4) == 0);
				offer(seg_pick, nb_pick, 0, '0, produced);
				if (produced != 0)
					rand_segs++;
				if (xfer_finished() && $urandom_range(0, 1) == 0)
					break;
			end
			ph++;
		end

		// hold the output off while segments keep coming, so the input backs up
		set_idle(0);
		settle();
		write_reg(REG_BLOCK_SIZE, 64'd6);
		write_reg(REG_STRIDE, 64'd9);
		write_reg(REG_BLOCK_TOTAL, 64'd40);
		hold_requests++;
		for (int j = 0; j < 12; j++)
			offer($urandom_range(5, 20), 1'b0, 0, '0, produced);

		set_idle(3);
		settle();
		$display("Sent %0d segments (%0d in pointer mode) over %0d register writes;",
			segs_sent, ptr_segs, reg_writes);
		$display("checked %0d commands with idle, stall and back-pressure phases.",
			cmds_checked);
		if (errors == 0)
			$display("PASS strided_gather_segmenter_core");
		else
			$display("FAIL strided_gather_segmenter_core");
		$finish;
	end

endmodule

FILE: sim.f
src/sgs_pkg.sv
src/sgs_datapath.sv
src/sgs_ctrl.sv
src/strided_gather_segmenter_core.sv
tb/strided_gather_segmenter_core_tb.sv
